/* rtl/srpu_pkg.sv */
// Shared types and constants for the SIMD reorder and permute unit.
`timescale 1ns / 1ps
`default_nettype none

package srpu_pkg;

  localparam int unsigned QW_W   = 128;
  localparam int unsigned MODE_W = 5;

  typedef logic [QW_W-1:0]   quad_t;
  typedef logic [MODE_W-1:0] mode_t;

  // Operation codes; the codes from 20 up are undefined and give a zero result.
  typedef enum logic [MODE_W-1:0] {
    OP_CPY_HALF    = 5'd0,
    OP_CPY_LO_DW   = 5'd1,
    OP_CPY_HI_DW   = 5'd2,
    OP_EXC_CTR_H   = 5'd3,
    OP_EXC_CTR_W   = 5'd4,
    OP_EXC_EVN_H   = 5'd5,
    OP_EXC_EVN_W   = 5'd6,
    OP_ILV_LO_B    = 5'd7,
    OP_ILV_LO_H    = 5'd8,
    OP_ILV_LO_W    = 5'd9,
    OP_ILV_HI_B    = 5'd10,
    OP_ILV_HI_H    = 5'd11,
    OP_ILV_HI_W    = 5'd12,
    OP_ILV_EVN_H   = 5'd13,
    OP_ILV_H       = 5'd14,
    OP_PACK_B      = 5'd15,
    OP_PACK_H      = 5'd16,
    OP_PACK_W      = 5'd17,
    OP_REV_H       = 5'd18,
    OP_ROT3_W      = 5'd19
  } op_t;

  localparam mode_t OP_LAST = 5'd19;

endpackage

`default_nettype wire

/* rtl/srpu_permute.sv */
// Combinational lane permutation network selected by the operation code.
`timescale 1ns / 1ps
`default_nettype none

module srpu_permute import srpu_pkg::*; (
  input  wire mode_t mode,
  input  wire quad_t rs,
  input  wire quad_t rt,
  output quad_t      rd
);

  always_comb begin
    rd = '0;
    case (mode)
      OP_CPY_HALF: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*i +: 16]      = rt[15:0];
          rd[64 + 16*i +: 16] = rt[79:64];
        end
      end
      OP_CPY_LO_DW: rd = {rs[63:0], rt[63:0]};
      OP_CPY_HI_DW: rd = {rt[127:64], rs[127:64]};
      OP_EXC_CTR_H: begin
        for (int d = 0; d < 2; d++) begin
          rd[64*d      +: 16] = rt[64*d      +: 16];
          rd[64*d + 16 +: 16] = rt[64*d + 32 +: 16];
          rd[64*d + 32 +: 16] = rt[64*d + 16 +: 16];
          rd[64*d + 48 +: 16] = rt[64*d + 48 +: 16];
        end
      end
      OP_EXC_EVN_H: begin
        for (int d = 0; d < 2; d++) begin
          rd[64*d      +: 16] = rt[64*d + 32 +: 16];
          rd[64*d + 16 +: 16] = rt[64*d + 16 +: 16];
          rd[64*d + 32 +: 16] = rt[64*d      +: 16];
          rd[64*d + 48 +: 16] = rt[64*d + 48 +: 16];
        end
      end
      OP_EXC_CTR_W: rd = {rt[127:96], rt[63:32], rt[95:64], rt[31:0]};
      OP_EXC_EVN_W: rd = {rt[127:96], rt[31:0], rt[63:32], rt[95:64]};
      OP_ILV_LO_B, OP_ILV_HI_B: begin
        for (int i = 0; i < 8; i++) begin
          if (mode == OP_ILV_HI_B) begin
            rd[16*i     +: 8] = rt[64 + 8*i +: 8];
            rd[16*i + 8 +: 8] = rs[64 + 8*i +: 8];
          end else begin
            rd[16*i     +: 8] = rt[8*i +: 8];
            rd[16*i + 8 +: 8] = rs[8*i +: 8];
          end
        end
      end
      OP_ILV_LO_H, OP_ILV_HI_H: begin
        for (int i = 0; i < 4; i++) begin
          if (mode == OP_ILV_HI_H) begin
            rd[32*i      +: 16] = rt[64 + 16*i +: 16];
            rd[32*i + 16 +: 16] = rs[64 + 16*i +: 16];
          end else begin
            rd[32*i      +: 16] = rt[16*i +: 16];
            rd[32*i + 16 +: 16] = rs[16*i +: 16];
          end
        end
      end
      OP_ILV_LO_W: rd = {rs[63:32], rt[63:32], rs[31:0], rt[31:0]};
      OP_ILV_HI_W: rd = {rs[127:96], rt[127:96], rs[95:64], rt[95:64]};
      OP_ILV_EVN_H: begin
        for (int i = 0; i < 4; i++) begin
          rd[32*i      +: 16] = rt[32*i +: 16];
          rd[32*i + 16 +: 16] = rs[32*i +: 16];
        end
      end
      OP_ILV_H: begin
        for (int i = 0; i < 4; i++) begin
          rd[32*i      +: 16] = rt[16*i      +: 16];
          rd[32*i + 16 +: 16] = rs[64 + 16*i +: 16];
        end
      end
      OP_PACK_B: begin
        for (int i = 0; i < 8; i++) begin
          rd[8*i      +: 8] = rt[16*i +: 8];
          rd[64 + 8*i +: 8] = rs[16*i +: 8];
        end
      end
      OP_PACK_H: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*i      +: 16] = rt[32*i +: 16];
          rd[64 + 16*i +: 16] = rs[32*i +: 16];
        end
      end
      OP_PACK_W: rd = {rs[95:64], rs[31:0], rt[95:64], rt[31:0]};
      OP_REV_H: begin
        for (int i = 0; i < 4; i++) begin
          rd[16*(3-i)      +: 16] = rt[16*i      +: 16];
          rd[64 + 16*(3-i) +: 16] = rt[64 + 16*i +: 16];
        end
      end
      OP_ROT3_W: rd = {rt[127:96], rt[31:0], rt[95:64], rt[63:32]};
      default: rd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/simd_reorder_permute_unit.sv */
// Top level of the SIMD reorder and permute unit: input register, permute, result register.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one word per cycle while results are taken, holding an operation
// code (in_tuser) and two 128-bit operands rs and rt (in_tdata), and returns one
// 128-bit result rd per accepted word. Each word is captured in an input
// register, passes through the lane permutation network, and lands in the
// result register that drives the output channel. Both registers advance
// whenever the stage behind them is empty or is being drained, so a new word is
// accepted every cycle as long as results are taken, and a finished result that
// waits for the consumer does not stop the input register from taking one more
// word. Operation codes 20 through 31 are undefined and yield an all-zero
// result. There is no configuration and no state that carries from one word to
// the next.

module simd_reorder_permute_unit import srpu_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,

  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [255:0] in_tdata,   // rs_low[63:0], rs_high[127:64], rt_low[191:128], rt_high[255:192]
  input  wire [4:0]   in_tuser,   // mode[4:0]

  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [127:0] out_tdata  // rd_low[63:0], rd_high[127:64]
);

  // Input register stage.
  logic  s1_valid_r, s1_valid_nxt;
  mode_t s1_mode_r;
  quad_t s1_rs_r;
  quad_t s1_rt_r;

  // Result register stage.
  logic  out_valid_r, out_valid_nxt;
  quad_t out_data_r;

  quad_t perm_rd;
  logic  out_adv;
  logic  in_fire;

  // The result register may load when it is empty or its word leaves this cycle.
  assign out_adv   = !out_valid_r || out_tready;
  // The input register may load when it is empty or its word moves on.
  assign in_tready = !s1_valid_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid flags qualify them.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_tuser;
      s1_rs_r   <= in_tdata[127:0];
      s1_rt_r   <= in_tdata[255:128];
    end
    if (out_adv && s1_valid_r) begin
      out_data_r <= perm_rd;
    end
  end

  srpu_permute u_permute (
    .mode (s1_mode_r),
    .rs   (s1_rs_r),
    .rt   (s1_rt_r),
    .rd   (perm_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An empty result register must never hold back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the result register is empty");

  // A word taken at the input is held in the input register on the next cycle.
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted word was lost from the input register");

  // A word moving into the result register shows exactly the permuted value.
  a_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> (out_tvalid && (out_tdata == $past(perm_rd))))
    else $error("result register does not hold the permuted word");

  // Undefined operation codes produce a zero result.
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_mode_r > OP_LAST)) |-> (perm_rd == '0))
    else $error("undefined operation code gave a nonzero result");

endmodule

`default_nettype wire
